FILE: rtl/core/gcli_pkg.sv
// Shared types, constants and codes for the glyph cache lookup and install block.
`timescale 1ns / 1ps

package gcli_pkg;

  localparam int SLOT_COUNT_DEF = 512;
  localparam int CNT_W          = 10;
  localparam int EPOCH_W        = 8;

  localparam logic [31:0] HASH_MUL_CODE = 32'd2654435761;
  localparam logic [31:0] HASH_MUL_SIZE = 32'd2246822519;

  localparam logic [CNT_W-1:0] FILL_LIMIT_RST = 10'd384;

  localparam logic REG_FILL_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_INSTALL = 2'd1,
    ST_FLUSHED = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic                      vld;
    logic [EPOCH_W-1:0]        epoch;
    logic [7:0]                code;
    logic [15:0]               size;
    logic [9:0]                width;
    logic [9:0]                height;
    logic signed [10:0]        xoff;
    logic signed [10:0]        yoff;
  } entry_t;

  typedef enum logic [2:0] {
    SW_INIT,
    SW_IDLE,
    SW_WAIT,
    SW_SCRUB,
    SW_TAIL
  } sw_state_t;

  typedef struct packed {
    logic busy;
    logic rd_own;
    logic wr_en;
  } sw_ctl_t;

endpackage

FILE: rtl/core/gcli_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module gcli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/gcli_hash.sv
// Slot hash: low bits of the two multiplicative hashes, combined by XOR.
`timescale 1ns / 1ps

module gcli_hash #(
  parameter int ADDR_W = 9
) (
  input  logic [7:0]        char_code,
  input  logic [15:0]       size_px,
  output logic [ADDR_W-1:0] slot
);

  localparam logic [ADDR_W-1:0] K_CODE = gcli_pkg::HASH_MUL_CODE[ADDR_W-1:0];
  localparam logic [ADDR_W-1:0] K_SIZE = gcli_pkg::HASH_MUL_SIZE[ADDR_W-1:0];

  logic [ADDR_W-1:0] code_x;
  logic [ADDR_W-1:0] size_x;
  logic [ADDR_W-1:0] prod_code;
  logic [ADDR_W-1:0] prod_size;

  // Only the low product bits reach the slot, so the low constant bits suffice.
  always_comb begin
    code_x    = ADDR_W'(char_code);
    size_x    = ADDR_W'(size_px);
    prod_code = code_x * K_CODE;
    prod_size = size_x * K_SIZE;
    slot      = prod_code ^ prod_size;
  end

endmodule

FILE: rtl/core/gcli_sweep.sv
// Sequencer for the clearing pass after reset and the stale-epoch scrub pass.
`timescale 1ns / 1ps

module gcli_sweep #(
  parameter int SLOT_COUNT = gcli_pkg::SLOT_COUNT_DEF,
  localparam int ADDR_W = $clog2(SLOT_COUNT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                scrub_req,
  input  logic                pipe_empty,
  input  logic                ent_stale,
  output gcli_pkg::sw_ctl_t   ctl,
  output logic [ADDR_W-1:0]   rd_addr,
  output logic [ADDR_W-1:0]   wr_addr
);

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(SLOT_COUNT - 1);

  gcli_pkg::sw_state_t state_r, state_nxt;
  logic [ADDR_W-1:0]   idx_r, idx_nxt;
  logic                chk_vld_r;
  logic [ADDR_W-1:0]   chk_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= gcli_pkg::SW_INIT;
      idx_r     <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      chk_vld_r <= (state_r == gcli_pkg::SW_SCRUB);
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= idx_r;
  end

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    ctl.busy   = 1'b1;
    ctl.rd_own = 1'b0;
    ctl.wr_en  = 1'b0;
    rd_addr    = idx_r;
    wr_addr    = chk_addr_r;
    unique case (state_r)
      gcli_pkg::SW_INIT: begin
        ctl.wr_en = 1'b1;
        wr_addr   = idx_r;
        if (idx_r == LAST_IDX) begin
          state_nxt = gcli_pkg::SW_IDLE;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      gcli_pkg::SW_IDLE: begin
        ctl.busy = 1'b0;
        if (scrub_req) begin
          state_nxt = gcli_pkg::SW_WAIT;
        end
      end
      gcli_pkg::SW_WAIT: begin
        if (pipe_empty) begin
          state_nxt = gcli_pkg::SW_SCRUB;
          idx_nxt   = '0;
        end
      end
      gcli_pkg::SW_SCRUB: begin
        ctl.rd_own = 1'b1;
        ctl.wr_en  = chk_vld_r && ent_stale;
        if (idx_r == LAST_IDX) begin
          state_nxt = gcli_pkg::SW_TAIL;
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end
      gcli_pkg::SW_TAIL: begin
        ctl.wr_en = chk_vld_r && ent_stale;
        state_nxt = gcli_pkg::SW_IDLE;
      end
      default: begin
        state_nxt = gcli_pkg::SW_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/glyph_cache_lookup_install.sv
// Top level of the direct-mapped glyph cache with lookup and install.
`timescale 1ns / 1ps

// A request beat is taken at a rising edge where start is high and busy is low.
// It carries a character code, a pixel size and the rasterizer metrics used on
// a miss. One result beat follows for every request: out_valid is high for one
// cycle per result, with the status, the slot and the glyph metrics. A new
// request can be taken in every cycle while busy is low; the path is an
// input register, a hash feeding the read port of the slot memory, and a tag
// compare and install stage ahead of the result register.
// The slot memory holds a valid bit and an epoch per entry; a flush advances the
// epoch. After reset busy stays high while the memory is cleared. Every
// 2**(EPOCH_W-1) flushes, busy rises, the pipeline drains and a scrub pass
// invalidates entries of the older epochs. The receiver cannot stall: each result
// is taken in the cycle it is shown. fill_limit sits at byte address 0 of the APB
// port; the user must write it only while idle, which the block does not enforce.

module glyph_cache_lookup_install #(
  parameter int SLOT_COUNT = gcli_pkg::SLOT_COUNT_DEF,
  localparam int ADDR_W = $clog2(SLOT_COUNT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [7:0]          in_char_code,
  input  logic [15:0]         in_size_px,
  input  logic [9:0]          in_render_width,
  input  logic [9:0]          in_render_height,
  input  logic signed [10:0]  in_render_xoff,
  input  logic signed [10:0]  in_render_yoff,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [ADDR_W-1:0]   out_slot,
  output logic [9:0]          out_glyph_width,
  output logic [9:0]          out_glyph_height,
  output logic signed [10:0]  out_glyph_xoff,
  output logic signed [10:0]  out_glyph_yoff,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int EW    = gcli_pkg::EPOCH_W;
  localparam int CW    = gcli_pkg::CNT_W;
  localparam int ENT_W = $bits(gcli_pkg::entry_t);

  logic                     p0_vld_r;
  logic [7:0]               p0_code_r;
  logic [15:0]              p0_size_r;
  logic [9:0]               p0_w_r;
  logic [9:0]               p0_h_r;
  logic signed [10:0]       p0_xo_r;
  logic signed [10:0]       p0_yo_r;

  logic                     s1_vld_r;
  logic [7:0]               s1_code_r;
  logic [15:0]              s1_size_r;
  logic [9:0]               s1_w_r;
  logic [9:0]               s1_h_r;
  logic signed [10:0]       s1_xo_r;
  logic signed [10:0]       s1_yo_r;
  logic [ADDR_W-1:0]        s1_slot_r;

  logic                     out_valid_r;
  logic [1:0]               out_status_r;
  logic [ADDR_W-1:0]        out_slot_r;
  logic [9:0]               out_w_r;
  logic [9:0]               out_h_r;
  logic signed [10:0]       out_xo_r;
  logic signed [10:0]       out_yo_r;

  logic [CW-1:0]            fill_limit_r;
  logic [CW-1:0]            fill_count_r, fill_count_nxt;
  logic [EW-1:0]            epoch_r, epoch_nxt;

  logic                     byp_en_r;
  logic [ADDR_W-1:0]        byp_addr_r;
  gcli_pkg::entry_t         byp_data_r;

  logic                     accept;
  logic                     cfg_wr;
  logic [ADDR_W-1:0]        hash_slot;
  logic [ADDR_W-1:0]        ram_raddr;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic [ENT_W-1:0]         ram_wdata;
  logic [ENT_W-1:0]         ram_rdata;

  gcli_pkg::sw_ctl_t        sw_ctl;
  logic [ADDR_W-1:0]        sw_rd_addr;
  logic [ADDR_W-1:0]        sw_wr_addr;
  logic                     ent_stale;
  logic                     scrub_req;

  gcli_pkg::entry_t         rd_ent;
  gcli_pkg::entry_t         scan_ent;
  gcli_pkg::entry_t         new_ent;
  gcli_pkg::status_t        status;
  logic                     live;
  logic                     hit;
  logic                     empty;
  logic                     install;
  logic                     flush;
  logic [CW-1:0]            cnt_base;

  assign accept = start && !busy;
  assign busy   = sw_ctl.busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == gcli_pkg::REG_FILL_LIMIT) begin
      prdata = {22'b0, fill_limit_r};
    end else begin
      prdata = '0;
    end
  end

  gcli_hash #(
    .ADDR_W(ADDR_W)
  ) u_hash (
    .char_code(p0_code_r),
    .size_px  (p0_size_r),
    .slot     (hash_slot)
  );

  gcli_sweep #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_sweep (
    .clk       (clk),
    .rst_n     (rst_n),
    .scrub_req (scrub_req),
    .pipe_empty(!p0_vld_r && !s1_vld_r),
    .ent_stale (ent_stale),
    .ctl       (sw_ctl),
    .rd_addr   (sw_rd_addr),
    .wr_addr   (sw_wr_addr)
  );

  gcli_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign ram_raddr = sw_ctl.rd_own ? sw_rd_addr : hash_slot;

  always_comb begin
    scan_ent  = gcli_pkg::entry_t'(ram_rdata);
    ent_stale = scan_ent.vld && (scan_ent.epoch[EW-1] != epoch_r[EW-1]);

    // The write of the previous beat lands at the edge that samples this read.
    if (byp_en_r && (byp_addr_r == s1_slot_r)) begin
      rd_ent = byp_data_r;
    end else begin
      rd_ent = gcli_pkg::entry_t'(ram_rdata);
    end

    live    = rd_ent.vld && (rd_ent.epoch == epoch_r);
    hit     = live && (rd_ent.code == s1_code_r) && (rd_ent.size == s1_size_r);
    empty   = (s1_w_r == 10'd0) || (s1_h_r == 10'd0);
    install = s1_vld_r && !hit && !empty;
    flush   = install && (fill_count_r >= fill_limit_r);

    epoch_nxt = flush ? EW'(epoch_r + 1'b1) : epoch_r;
    cnt_base  = flush ? '0 : fill_count_r;
    if (!install) begin
      fill_count_nxt = fill_count_r;
    end else if (live && !flush) begin
      fill_count_nxt = cnt_base;
    end else begin
      fill_count_nxt = CW'(cnt_base + 1'b1);
    end

    // A new half of the epoch range begins: entries of the other half go stale.
    scrub_req = flush && (epoch_nxt[EW-2:0] == '0);

    if (hit) begin
      status = gcli_pkg::ST_HIT;
    end else if (empty) begin
      status = gcli_pkg::ST_EMPTY;
    end else if (flush) begin
      status = gcli_pkg::ST_FLUSHED;
    end else begin
      status = gcli_pkg::ST_INSTALL;
    end

    new_ent.vld    = 1'b1;
    new_ent.epoch  = epoch_nxt;
    new_ent.code   = s1_code_r;
    new_ent.size   = s1_size_r;
    new_ent.width  = s1_w_r;
    new_ent.height = s1_h_r;
    new_ent.xoff   = s1_xo_r;
    new_ent.yoff   = s1_yo_r;

    ram_we    = sw_ctl.wr_en || install;
    ram_waddr = sw_ctl.wr_en ? sw_wr_addr : s1_slot_r;
    ram_wdata = sw_ctl.wr_en ? '0 : new_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r     <= 1'b0;
      s1_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      byp_en_r     <= 1'b0;
      fill_limit_r <= gcli_pkg::FILL_LIMIT_RST;
      fill_count_r <= '0;
      epoch_r      <= '0;
    end else begin
      p0_vld_r     <= accept;
      s1_vld_r     <= p0_vld_r;
      out_valid_r  <= s1_vld_r;
      byp_en_r     <= ram_we;
      fill_count_r <= fill_count_nxt;
      epoch_r      <= epoch_nxt;
      if (cfg_wr && (paddr[2] == gcli_pkg::REG_FILL_LIMIT)) begin
        fill_limit_r <= pwdata[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p0_code_r <= in_char_code;
      p0_size_r <= in_size_px;
      p0_w_r    <= in_render_width;
      p0_h_r    <= in_render_height;
      p0_xo_r   <= in_render_xoff;
      p0_yo_r   <= in_render_yoff;
    end
    s1_code_r  <= p0_code_r;
    s1_size_r  <= p0_size_r;
    s1_w_r     <= p0_w_r;
    s1_h_r     <= p0_h_r;
    s1_xo_r    <= p0_xo_r;
    s1_yo_r    <= p0_yo_r;
    s1_slot_r  <= hash_slot;
    byp_addr_r <= ram_waddr;
    byp_data_r <= gcli_pkg::entry_t'(ram_wdata);
    out_status_r <= status;
    out_slot_r   <= s1_slot_r;
    if (hit) begin
      out_w_r  <= rd_ent.width;
      out_h_r  <= rd_ent.height;
      out_xo_r <= rd_ent.xoff;
      out_yo_r <= rd_ent.yoff;
    end else begin
      out_w_r  <= s1_w_r;
      out_h_r  <= s1_h_r;
      out_xo_r <= s1_xo_r;
      out_yo_r <= s1_yo_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_glyph_width  = out_w_r;
  assign out_glyph_height = out_h_r;
  assign out_glyph_xoff   = out_xo_r;
  assign out_glyph_yoff   = out_yo_r;

`ifndef SYNTHESIS
  a_result_follows_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(s1_vld_r))
    else $error("result beat without a lookup in the previous cycle");

  a_sweep_item_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sw_ctl.wr_en && install))
    else $error("sweep write collides with an install");

  a_scrub_on_empty_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    sw_ctl.rd_own |-> (!p0_vld_r && !s1_vld_r))
    else $error("scrub pass runs while requests are in flight");

  a_flush_leaves_one: assert property (@(posedge clk) disable iff (!rst_n)
    flush |=> (fill_count_r == CW'(1)))
    else $error("fill count is not one after a flushing install");
`endif

endmodule

FILE: tb/glyph_cache_lookup_install_tb.sv
// Self-checking testbench for the direct-mapped glyph cache lookup and install block.
`timescale 1ns / 1ps

module glyph_cache_lookup_install_tb;

  localparam int SLOTS = gcli_pkg::SLOT_COUNT_DEF;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [2:0] FILL_LIMIT_ADDR = {gcli_pkg::REG_FILL_LIMIT, 2'b00};
  localparam logic [2:0] UNUSED_ADDR = 3'd4;
  localparam int POOL_SIZE = 24;

  typedef struct packed {
    logic [9:0]         width;
    logic [9:0]         height;
    logic signed [10:0] xoff;
    logic signed [10:0] yoff;
  } glyph_metrics_t;

  typedef struct packed {
    logic [7:0]     code;
    logic [15:0]    size;
    glyph_metrics_t metrics;
  } glyph_req_t;

  typedef struct packed {
    gcli_pkg::status_t    status;
    logic [SLOT_BITS-1:0] slot;
    glyph_metrics_t       metrics;
  } glyph_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [7:0] in_char_code = '0;
  logic [15:0] in_size_px = '0;
  logic [9:0] in_render_width = '0;
  logic [9:0] in_render_height = '0;
  logic signed [10:0] in_render_xoff = '0;
  logic signed [10:0] in_render_yoff = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic [SLOT_BITS-1:0] out_slot;
  logic [9:0] out_glyph_width;
  logic [9:0] out_glyph_height;
  logic signed [10:0] out_glyph_xoff;
  logic signed [10:0] out_glyph_yoff;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  glyph_cache_lookup_install dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_char_code(in_char_code), .in_size_px(in_size_px),
    .in_render_width(in_render_width), .in_render_height(in_render_height),
    .in_render_xoff(in_render_xoff), .in_render_yoff(in_render_yoff),
    .out_valid(out_valid), .out_status(out_status), .out_slot(out_slot),
    .out_glyph_width(out_glyph_width), .out_glyph_height(out_glyph_height),
    .out_glyph_xoff(out_glyph_xoff), .out_glyph_yoff(out_glyph_yoff),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  bit             cache_valid [SLOTS];
  logic [23:0]    cache_tag [SLOTS];
  glyph_metrics_t cache_metrics [SLOTS];
  logic [9:0]     fill_count = '0;
  logic [9:0]     fill_limit = gcli_pkg::FILL_LIMIT_RST;
  glyph_res_t     pending_results [$];

  int mismatch_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int hit_count = 0;
  int install_count = 0;
  int flush_count = 0;
  int empty_count = 0;
  int idle_cycles = 0;
  bit idle_on = 1'b1;
  logic [23:0] key_pool [POOL_SIZE];

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int expv, input int gotv);
    if (expv != gotv)
      flag_mismatch($sformatf("%s expected %0d, got %0d", name, expv, gotv));
  endtask

  function automatic logic [SLOT_BITS-1:0] slot_of(input logic [7:0] code,
                                                   input logic [15:0] size);
    logic [31:0] h;
    h = ({24'b0, code} * gcli_pkg::HASH_MUL_CODE) ^
        ({16'b0, size} * gcli_pkg::HASH_MUL_SIZE);
    return h[SLOT_BITS-1:0];
  endfunction

  function automatic void predict_lookup(input glyph_req_t r);
    logic [SLOT_BITS-1:0] s;
    logic [23:0] tag;
    glyph_res_t e;
    s = slot_of(r.code, r.size);
    tag = {r.code, r.size};
    e.slot = s;
    if (cache_valid[s] && cache_tag[s] == tag) begin
      e.status = gcli_pkg::ST_HIT;
      e.metrics = cache_metrics[s];
      hit_count++;
    end else begin
      e.metrics = r.metrics;
      if (r.metrics.width == 0 || r.metrics.height == 0) begin
        e.status = gcli_pkg::ST_EMPTY;
        empty_count++;
      end else begin
        e.status = gcli_pkg::ST_INSTALL;
        if (fill_count >= fill_limit) begin
          cache_valid = '{default: 1'b0};
          fill_count = '0;
          e.status = gcli_pkg::ST_FLUSHED;
          flush_count++;
        end
        if (cache_valid[s])
          fill_count--;
        cache_valid[s] = 1'b1;
        cache_tag[s] = tag;
        cache_metrics[s] = r.metrics;
        fill_count++;
        install_count++;
      end
    end
    pending_results.push_back(e);
  endfunction

  always @(posedge clk) begin
    glyph_res_t e;
    glyph_req_t r;
    if (rst_n) begin
      if (out_valid) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          flag_mismatch("result beat with no request outstanding");
        end else begin
          e = pending_results.pop_front();
          check_field("status", int'(e.status), int'(out_status));
          check_field("slot", int'(e.slot), int'(out_slot));
          check_field("width", int'(e.metrics.width), int'(out_glyph_width));
          check_field("height", int'(e.metrics.height), int'(out_glyph_height));
          check_field("xoff", int'(e.metrics.xoff), int'(out_glyph_xoff));
          check_field("yoff", int'(e.metrics.yoff), int'(out_glyph_yoff));
        end
      end
      if (start && !busy) begin
        r.code = in_char_code;
        r.size = in_size_px;
        r.metrics = '{in_render_width, in_render_height, in_render_xoff, in_render_yoff};
        predict_lookup(r);
        requests_sent++;
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == FILL_LIMIT_ADDR)
            fill_limit = pwdata[9:0];
        end else if (paddr == FILL_LIMIT_ADDR) begin
          check_field("fill_limit readback", int'(fill_limit), int'(prdata));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic glyph_req_t glyph(input logic [7:0] code, input logic [15:0] size,
                                       input logic [9:0] w, input logic [9:0] h,
                                       input logic signed [10:0] x,
                                       input logic signed [10:0] y);
    glyph_req_t r;
    r.code = code;
    r.size = size;
    r.metrics = '{w, h, x, y};
    return r;
  endfunction

  task automatic send_glyph(input glyph_req_t r);
    int gap;
    if (idle_on && $urandom_range(99) < 4) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start = 1'b1;
    in_char_code = r.code;
    in_size_px = r.size;
    in_render_width = r.metrics.width;
    in_render_height = r.metrics.height;
    in_render_xoff = r.metrics.xoff;
    in_render_yoff = r.metrics.yoff;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic apb_access(input bit is_write, input logic [2:0] addr,
                            input logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = is_write;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic program_register(input logic [2:0] addr, input logic [31:0] value);
    settle();
    apb_access(1'b1, addr, value);
    apb_access(1'b0, FILL_LIMIT_ADDR, '0);
  endtask

  function automatic glyph_req_t random_glyph(input bit fresh_only, input bit allow_empty);
    glyph_req_t r;
    logic [23:0] key;
    int pick;
    if (!fresh_only && $urandom_range(99) < 60) begin
      key = key_pool[$urandom_range(POOL_SIZE - 1)];
      r.code = key[23:16];
      r.size = key[15:0];
    end else begin
      r.code = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 5)
        r.size = '0;
      else if (pick < 35)
        r.size = 16'($urandom_range(65535));
      else
        r.size = 16'($urandom_range(1, 64));
    end
    r.metrics.width = 10'($urandom_range(1, 1023));
    r.metrics.height = 10'($urandom_range(1, 1023));
    r.metrics.xoff = 11'($urandom_range(2047));
    r.metrics.yoff = 11'($urandom_range(2047));
    if (allow_empty) begin
      pick = $urandom_range(99);
      if (pick < 5)
        r.metrics.width = '0;
      else if (pick < 10)
        r.metrics.height = '0;
    end
    return r;
  endfunction

  task automatic send_fresh(input int count);
    repeat (count) send_glyph(random_glyph(1'b1, 1'b0));
  endtask

  task automatic test_directed();
    logic [15:0] twin_size;
    bit found;
    send_glyph(glyph(8'd0, 16'd1, 10'd1, 10'd1, 11'sd0, 11'sd0));
    send_glyph(glyph(8'd255, 16'd65535, 10'd1023, 10'd1023, 11'sd1023, 11'sd1023));
    send_glyph(glyph(8'd255, 16'd65535, 10'd5, 10'd5, -11'sd1024, -11'sd1024));
    send_glyph(glyph(8'd0, 16'd1, 10'd7, 10'd7, 11'sd1, 11'sd1));
    send_glyph(glyph(8'd128, 16'd0, 10'd1023, 10'd1, -11'sd1024, 11'sd1023));
    send_glyph(glyph(8'd128, 16'd0, 10'd2, 10'd2, 11'sd0, 11'sd0));
    send_glyph(glyph(8'd7, 16'd40, 10'd0, 10'd9, 11'sd3, -11'sd3));
    send_glyph(glyph(8'd7, 16'd40, 10'd9, 10'd0, -11'sd5, 11'sd5));
    send_glyph(glyph(8'd7, 16'd40, 10'd0, 10'd0, 11'sd1023, -11'sd1024));
    send_glyph(glyph(8'd7, 16'd40, 10'd12, 10'd14, -11'sd2, 11'sd2));
    send_glyph(glyph(8'd7, 16'd40, 10'd0, 10'd0, 11'sd0, 11'sd0));
    send_glyph(glyph(8'd0, 16'd1, 10'd0, 10'd0, 11'sd0, 11'sd0));
    // A second tag that hashes onto the same slot forces replacement back and forth.
    found = 1'b0;
    twin_size = '0;
    for (int s = 1; s < 65536 && !found; s++) begin
      if (slot_of(8'd66, 16'(s)) == slot_of(8'd65, 16'd12)) begin
        twin_size = 16'(s);
        found = 1'b1;
      end
    end
    send_glyph(glyph(8'd65, 16'd12, 10'd100, 10'd200, 11'sd10, -11'sd20));
    send_glyph(glyph(8'd66, twin_size, 10'd300, 10'd400, -11'sd30, 11'sd40));
    send_glyph(glyph(8'd65, 16'd12, 10'd101, 10'd201, 11'sd11, -11'sd21));
    send_glyph(glyph(8'd65, 16'd12, 10'd1, 10'd1, 11'sd0, 11'sd0));
    send_glyph(glyph(8'd66, twin_size, 10'd301, 10'd401, -11'sd31, 11'sd41));
    send_glyph(glyph(8'd66, twin_size, 10'd0, 10'd1, 11'sd0, 11'sd0));
  endtask

  task automatic test_fill_limits();
    program_register(FILL_LIMIT_ADDR, 32'd1);
    send_fresh(3);
    program_register(FILL_LIMIT_ADDR, 32'd0);
    send_fresh(3);
    program_register(FILL_LIMIT_ADDR, 32'd512);
    send_fresh(8);
    program_register(FILL_LIMIT_ADDR, 32'd3);
    send_fresh(2);
    program_register(UNUSED_ADDR, 32'd5);
    send_fresh(2);
    program_register(FILL_LIMIT_ADDR, 32'd1023);
    send_fresh(2);
  endtask

  task automatic test_flush_storm();
    program_register(FILL_LIMIT_ADDR, 32'd0);
    send_fresh(150);
  endtask

  task automatic test_random_traffic(input logic [9:0] limit, input int count,
                                     input bit with_idle);
    program_register(FILL_LIMIT_ADDR, {22'b0, limit});
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = {8'($urandom_range(255)), 16'($urandom_range(1, 64))};
    idle_on = with_idle;
    repeat (count) send_glyph(random_glyph(1'b0, 1'b1));
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    settle();
    apb_access(1'b0, FILL_LIMIT_ADDR, '0);
    test_directed();
    test_fill_limits();
    test_flush_storm();
    test_random_traffic(10'd384, 360, 1'b1);
    test_random_traffic(10'd16, 200, 1'b0);
    test_random_traffic(10'd1, 100, 1'b1);
    test_random_traffic(10'd512, 200, 1'b1);
    test_random_traffic(10'd1023, 100, 1'b1);
    settle();
    $display("Sent %0d requests and checked %0d results over fill limits 0 to 1023.",
             requests_sent, results_checked);
    $display("Hits %0d, installs %0d, flushes %0d, empty glyphs %0d.",
             hit_count, install_count, flush_count, empty_count);
    if (mismatch_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: glyph_cache_lookup_install.f
rtl/core/gcli_pkg.sv
rtl/core/gcli_ram.sv
rtl/core/gcli_hash.sv
rtl/core/gcli_sweep.sv
rtl/core/glyph_cache_lookup_install.sv
tb/glyph_cache_lookup_install_tb.sv
